[src/percent_decoder_macros.svh]
// Assertion macros for the percent decoder.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef PERCENT_DECODER_MACROS_SVH
`define PERCENT_DECODER_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define PD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("percent_decoder: implication check failed");

// The condition must never be true outside reset.
`define PD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("percent_decoder: forbidden condition seen");

`endif

[src/pd_pkg.sv]
// Shared types, character constants and the hex digit function for the
// percent decoder. No dependencies.
`timescale 1ns / 1ps

package pd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  // Result queue depth and its level width.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QLVL_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } pd_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       empty;
    logic       last;
  } pd_result_t;

  // Non-hex characters count as nibble zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = c - CH_UP_A + HEX_TEN;
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      d = c - CH_LO_A + HEX_TEN;
    end
    return d[3:0];
  endfunction

endpackage

[src/percent_decoder.sv]
// Streaming URL percent decoder, one byte per item.
// Results are registered in the result queue before they are offered.
// Throughput: one item per cycle unless in_stall; an item can give two results,
// buffered in a four-entry result queue that stalls input above two results.
// Reset (rst_n low, synchronous) clears phase, nibble, ended flag and the queue.
`timescale 1ns / 1ps

`include "percent_decoder_macros.svh"

module percent_decoder
  import pd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_empty,
  output logic       out_last
);

  logic              in_fire, out_fire;
  pd_result_t        res0, res1, head;
  logic [1:0]        res_cnt, push_cnt;
  logic [QLVL_W-1:0] level;

  // Room for two more results is needed before an item is taken.
  assign in_stall = (level > QLVL_W'(QDEPTH - 2));
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign push_cnt = in_fire ? res_cnt : 2'd0;

  pd_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (in_fire),
    .byte_in (in_byte),
    .last_in (in_last),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  pd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push0    (res0),
    .push1    (res1),
    .push_cnt (push_cnt),
    .pop      (out_fire),
    .head     (head),
    .level    (level)
  );

  assign out_valid = (level != '0);
  assign out_byte  = head.data;
  assign out_empty = head.empty;
  assign out_last  = head.last;

  `PD_ASSERT_NEVER(a_queue_bound, level > QLVL_W'(QDEPTH))
  `PD_ASSERT_IMPL(a_marker_is_last, out_valid && out_empty, out_last && out_byte == 8'd0)
  `PD_ASSERT_IMPL(a_no_zero_byte, out_valid && !out_empty, out_byte != 8'd0)
  `PD_ASSERT_IMPL(a_two_need_room, in_fire && res_cnt == 2'd2, level <= QLVL_W'(QDEPTH - 2))

endmodule

[src/pd_step.sv]
// Escape phase machine of the percent decoder: holds phase, high nibble and
// the ended flag, and forms up to two results per item. Uses pd_pkg.
`timescale 1ns / 1ps

module pd_step
  import pd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output pd_result_t res0,
  output pd_result_t res1,
  output logic [1:0] res_cnt
);

  pd_phase_t  phase_r, phase_nxt;
  logic [3:0] hi_r, hi_nxt;
  logic       ended_r, ended_nxt;

  logic [7:0] c0, c1;
  logic       v0, v1, k0, k1, e_mid, e_end;
  logic [1:0] n_bytes;

  always_comb begin
    c0        = byte_in;
    c1        = byte_in;
    v0        = 1'b0;
    v1        = 1'b0;
    phase_nxt = PH_IDLE;
    hi_nxt    = hi_r;
    unique case (phase_r)
      PH_PCT: begin
        if (last_in) begin
          c0 = CH_PERCENT;
          v0 = 1'b1;
          v1 = 1'b1;
        end else begin
          hi_nxt    = hex_value(byte_in);
          phase_nxt = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        c0 = {hi_r, hex_value(byte_in)};
        v0 = 1'b1;
      end
      default: begin
        if (byte_in == CH_PERCENT && !last_in) begin
          phase_nxt = PH_PCT;
        end else begin
          v0 = 1'b1;
        end
      end
    endcase

    // A zero byte ends the output; no byte after it in the string is emitted.
    k0    = v0 && !ended_r && (c0 != 8'd0);
    e_mid = ended_r || (v0 && c0 == 8'd0);
    k1    = v1 && !e_mid && (c1 != 8'd0);
    e_end = e_mid || (v1 && c1 == 8'd0);

    n_bytes   = {1'b0, k0} + {1'b0, k1};
    ended_nxt = e_end;
    if (last_in) begin
      phase_nxt = PH_IDLE;
      hi_nxt    = 4'd0;
      ended_nxt = 1'b0;
    end
  end

  always_comb begin
    res0 = '{data: (k0 ? c0 : c1), empty: 1'b0, last: 1'b0};
    res1 = '{data: c1, empty: 1'b0, last: last_in};
    res_cnt = n_bytes;
    if (last_in) begin
      if (n_bytes == 2'd0) begin
        res0    = '{data: 8'd0, empty: 1'b1, last: 1'b1};
        res_cnt = 2'd1;
      end else if (n_bytes == 2'd1) begin
        res0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hi_r    <= 4'd0;
      ended_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hi_r    <= hi_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

[src/pd_queue.sv]
// Small result queue: takes up to two results a cycle, gives one.
// Uses pd_pkg for the result type and depth.
`timescale 1ns / 1ps

module pd_queue
  import pd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pd_result_t        push0,
  input  pd_result_t        push1,
  input  logic [1:0]        push_cnt,
  input  logic              pop,
  output pd_result_t        head,
  output logic [QLVL_W-1:0] level
);

  pd_result_t        mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_plus1;
  logic [QLVL_W-1:0] level_r, level_nxt;

  always_comb begin
    wr_plus1  = wr_r + QPTR_W'(1);
    wr_nxt    = wr_r + QPTR_W'(push_cnt);
    rd_nxt    = pop ? rd_r + QPTR_W'(1) : rd_r;
    level_nxt = level_r + QLVL_W'(push_cnt) - QLVL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_plus1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      level_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      level_r <= level_nxt;
    end
  end

  assign head  = mem_r[rd_r];
  assign level = level_r;

endmodule

[tb/tb.sv]
// Self-checking testbench for the streaming percent decoder: directed strings, then random ones.
// Depends on pd_pkg for the character constants, the phase enum and the result struct.
`timescale 1ns / 1ps

module tb;
  import pd_pkg::*;

  localparam int NDIR      = 26;
  localparam int RAND_ITEMS = 1050;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [7:0] b;
    logic       l;
    int         nt;     // number of typed results, or -1 to use the decoder model
    pd_result_t r0;
    pd_result_t r1;
  } dir_row_t;

  typedef struct {
    logic [7:0] b;
    logic       l;
    int         nt;
    pd_result_t r0;
    pd_result_t r1;
    bit         drain;  // wait for every pending result before offering this item
  } stim_t;

  localparam pd_result_t NO_RES = '0;
  localparam pd_result_t MARKER = {8'h00, 1'b1, 1'b1};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h41;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_empty;
  logic       out_last;

  percent_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_empty(out_empty),
    .out_last (out_last)
  );

  dir_row_t dir_tab [NDIR] = '{
    '{"A",        1'b1,  1, {"A", 1'b0, 1'b1},       NO_RES},
    '{8'h01,      1'b0,  1, {8'h01, 1'b0, 1'b0},     NO_RES},
    '{8'hFF,      1'b1,  1, {8'hFF, 1'b0, 1'b1},     NO_RES},
    '{CH_PERCENT, 1'b0,  0, NO_RES,                  NO_RES},
    '{"4",        1'b0,  0, NO_RES,                  NO_RES},
    '{"1",        1'b1,  1, {"A", 1'b0, 1'b1},       NO_RES},
    '{CH_PERCENT, 1'b0, -1, NO_RES,                  NO_RES},
    '{"6",        1'b0, -1, NO_RES,                  NO_RES},
    '{"a",        1'b0, -1, NO_RES,                  NO_RES},
    '{"z",        1'b1, -1, NO_RES,                  NO_RES},
    '{CH_PERCENT, 1'b0,  0, NO_RES,                  NO_RES},
    '{"F",        1'b0,  0, NO_RES,                  NO_RES},
    '{"f",        1'b1,  1, {8'hFF, 1'b0, 1'b1},     NO_RES},
    '{CH_PERCENT, 1'b0,  0, NO_RES,                  NO_RES},
    '{"x",        1'b1,  2, {CH_PERCENT, 1'b0, 1'b0}, {"x", 1'b0, 1'b1}},
    '{CH_PERCENT, 1'b1,  1, {CH_PERCENT, 1'b0, 1'b1}, NO_RES},
    '{CH_PERCENT, 1'b0,  0, NO_RES,                  NO_RES},
    '{"0",        1'b0,  0, NO_RES,                  NO_RES},
    '{"0",        1'b0,  0, NO_RES,                  NO_RES},
    '{"B",        1'b1,  1, MARKER,                  NO_RES},
    '{CH_PERCENT, 1'b0, -1, NO_RES,                  NO_RES},
    '{"g",        1'b0, -1, NO_RES,                  NO_RES},
    '{"Z",        1'b1,  1, MARKER,                  NO_RES},
    '{CH_PERCENT, 1'b0, -1, NO_RES,                  NO_RES},
    '{CH_PERCENT, 1'b0, -1, NO_RES,                  NO_RES},
    '{"7",        1'b1, -1, NO_RES,                  NO_RES}
  };

  stim_t      stim_q [$];
  stim_t      offer_q [$];
  pd_result_t exp_q [$];

  int n_items = 0;
  int n_strings = 0;
  int n_results = 0;
  int n_markers = 0;
  int n_pauses = 0;
  int n_errors = 0;

  // Decoder state as seen by the scoreboard.
  pd_phase_t  dec_phase = PH_IDLE;
  logic [3:0] dec_hi = 4'd0;
  logic       dec_ended = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected", exp_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 4'(c - CH_ZERO);
    if (c >= CH_UP_A && c <= CH_UP_F) return 4'(c - CH_UP_A + HEX_TEN);
    if (c >= CH_LO_A && c <= CH_LO_F) return 4'(c - CH_LO_A + HEX_TEN);
    return 4'd0;
  endfunction

  function automatic void put_byte(input logic [7:0] v, inout pd_result_t [1:0] res,
                                   inout int n);
    if (dec_ended) return;
    // A zero byte truncates the output like a string terminator.
    if (v == 8'd0) begin
      dec_ended = 1'b1;
      return;
    end
    res[n] = {v, 1'b0, 1'b0};
    n++;
  endfunction

  function automatic int decode_step(input logic [7:0] b, input logic l,
                                     output pd_result_t [1:0] res);
    int n;
    n = 0;
    res = '0;
    case (dec_phase)
      PH_PCT: begin
        if (l) begin
          put_byte(CH_PERCENT, res, n);
          put_byte(b, res, n);
        end else begin
          dec_hi = nibble_of(b);
          dec_phase = PH_DIGIT;
        end
      end
      PH_DIGIT: begin
        put_byte({dec_hi, nibble_of(b)}, res, n);
        dec_phase = PH_IDLE;
      end
      default: begin
        dec_phase = PH_IDLE;
        if (b == CH_PERCENT && !l) dec_phase = PH_PCT;
        else put_byte(b, res, n);
      end
    endcase
    if (l) begin
      if (n == 0) begin
        res[0] = MARKER;
        n = 1;
      end else begin
        res[n-1].last = 1'b1;
      end
      dec_phase = PH_IDLE;
      dec_hi = 4'd0;
      dec_ended = 1'b0;
    end
    return n;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return CH_ZERO + {4'd0, v};
    if ($urandom_range(0, 1) == 0) return CH_UP_A + {4'd0, v} - HEX_TEN;
    return CH_LO_A + {4'd0, v} - HEX_TEN;
  endfunction

  // Mostly well-formed escapes and plain text; the string length cuts escapes at random.
  function automatic int add_random_string(input bit pause_first);
    logic [7:0] chars [$];
    logic [7:0] b;
    int len;
    int pick;
    stim_t s;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 12);
    while (chars.size() < len) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        do b = 8'($urandom_range(1, 255)); while (b == CH_PERCENT);
        chars = {chars, b};
      end else if (pick < 80) begin
        chars = {chars, CH_PERCENT};
        chars = {chars, hex_char(4'($urandom_range(0, 15)))};
        chars = {chars, hex_char(4'($urandom_range(0, 15)))};
      end else if (pick < 85) begin
        chars = {chars, CH_PERCENT};
        chars = {chars, CH_ZERO};
        chars = {chars, CH_ZERO};
      end else if (pick < 93) begin
        chars = {chars, CH_PERCENT};
        chars = {chars, 8'($urandom_range(1, 255))};
        chars = {chars, 8'($urandom_range(1, 255))};
      end else begin
        chars = {chars, CH_PERCENT};
      end
    end
    for (int i = 0; i < len; i++) begin
      s = '{chars[i], (i == len - 1), -1, NO_RES, NO_RES, (pause_first && i == 0)};
      stim_q = {stim_q, s};
    end
    return len;
  endfunction

  always @(posedge clk) begin : scoreboard
    stim_t cur;
    pd_result_t [1:0] res;
    pd_result_t want;
    int n;
    int k;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        cur = offer_q.pop_front();
        n = decode_step(in_byte, in_last, res);
        n_items++;
        if (in_last) n_strings++;
        if (cur.nt >= 0) begin
          if (cur.nt > 0) exp_q = {exp_q, cur.r0};
          if (cur.nt > 1) exp_q = {exp_q, cur.r1};
        end else begin
          for (k = 0; k < n; k++) exp_q = {exp_q, res[k]};
        end
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (out_empty) n_markers++;
        if (exp_q.size() == 0) begin
          $display("%0t: unexpected result byte %02h empty %0b last %0b", $time,
                   out_byte, out_empty, out_last);
          n_errors++;
        end else begin
          want = exp_q.pop_front();
          // The byte carries no meaning on an end marker.
          if (!want.empty && out_byte !== want.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
            n_errors++;
          end
          if (out_empty !== want.empty) begin
            $display("%0t: out_empty expected %0b actual %0b", $time, want.empty, out_empty);
            n_errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last expected %0b actual %0b", $time, want.last, out_last);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin : receiver
    int seg;
    int mode;
    int cnt;
    bit held;
    held = 1'b0;
    cnt = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      // One long hold-off so the result queue fills and the input backs up.
      if (!held && n_items >= 400) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(20, 150);
      repeat (seg) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (cnt % 3 == 0);
        endcase
        cnt++;
        @(posedge clk);
      end
    end
  end

  initial begin : sender
    stim_t item;
    int burst;
    int gap;
    int total;
    int wait_cycles;
    for (int i = 0; i < NDIR; i++) begin
      item = '{dir_tab[i].b, dir_tab[i].l, dir_tab[i].nt, dir_tab[i].r0, dir_tab[i].r1, 1'b0};
      stim_q = {stim_q, item};
    end
    total = 0;
    while (total < RAND_ITEMS) begin
      total += add_random_string(total == 0 || (total >= RAND_ITEMS / 2 && n_pauses == 0
                                                && total < RAND_ITEMS / 2 + 12));
    end

    while (!rst_n) @(posedge clk);
    burst = $urandom_range(1, 24);
    while (stim_q.size() > 0) begin
      item = stim_q.pop_front();
      if (item.drain) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (exp_q.size() != 0) @(posedge clk);
        n_pauses++;
      end
      offer_q = {offer_q, item};
      in_valid <= 1'b1;
      in_byte <= item.b;
      in_last <= item.l;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      burst--;
      if (burst <= 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait_cycles = 0;
    while (exp_q.size() != 0 && wait_cycles < 10000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (exp_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, exp_q.size());
      n_errors += exp_q.size();
    end
    repeat (10) @(posedge clk);
    $display("Decoded %0d items in %0d strings; %0d results checked, %0d end markers.",
             n_items, n_strings, n_results, n_markers);
    $display("Included a %0d-cycle output hold-off and %0d full drains of the sender.",
             HOLD_CYCLES, n_pauses);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
